/* hw/rtl/ggbi_pkg.sv */
// ----------------------------------------------------------------------------
// ggbi_pkg
// Shared constants for the geoid grid bilinear interpolation core: grid size,
// field widths, coordinate limits and item kinds.
// ----------------------------------------------------------------------------
package ggbi_pkg;

    localparam int GRID_ROWS = 721;
    localparam int GRID_COLS = 1440;
    localparam int GRID_SIZE = GRID_ROWS * GRID_COLS;

    localparam int ROW_W  = $clog2(GRID_ROWS);
    localparam int COL_W  = $clog2(GRID_COLS + 1);
    localparam int ADDR_W = 20;

    localparam int IDX_W = 20;
    localparam int HGT_W = 16;
    localparam int LAT_W = 24;
    localparam int LON_W = 25;
    localparam int SEP_W = 24;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 24;

    // Q16 degree limits
    localparam logic signed [LAT_W-1:0] LAT_MAX = 24'sd5898240;
    localparam logic signed [LAT_W-1:0] LAT_MIN = -24'sd5898240;
    localparam logic signed [LON_W-1:0] LON_MAX = 25'sd11796480;
    localparam logic signed [LON_W-1:0] LON_MIN = -25'sd11796480;
    localparam logic [LON_W-1:0]        DEG360  = 25'd23592960;
    localparam logic [LON_W-1:0]        DEG90   = 25'd5898240;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

endpackage

/* hw/rtl/geoid_grid_bilinear_interp_core.sv */
// ----------------------------------------------------------------------------
// geoid_grid_bilinear_interp_core
// Quarter-degree geoid height grid with bilinear interpolation of queries.
// ----------------------------------------------------------------------------
// A load item (tuser = 0) writes one grid entry; loads at or beyond the grid
// size are dropped. A query item (tuser = 1) occupies the core from acceptance
// until it finishes, and no new item is taken meanwhile: the four
// neighbouring entries come from the one single-port grid memory, and six
// multiply steps run through the one shared 34x18 multiplier (four column
// weights, two row blends). An out-of-range coordinate skips the reads and the
// multiply steps. A finished query also holds the core while the
// previous result still waits in the output register; otherwise the result
// sits there and the next item is taken while it waits. Separation is in
// centimetres with 8 fractional bits, floored; an out-of-range coordinate
// returns zero with the valid flag (m_tuser) clear. The grid has no reset or
// clearing pass; entries must be loaded before a query touches them.
// ----------------------------------------------------------------------------
module geoid_grid_bilinear_interp_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // entry_index[19:0], entry_value[35:20], latitude[59:36], longitude[84:60]
    input  logic [ggbi_pkg::IN_DATA_W-1:0]     s_tdata,
    // mode[0]
    input  logic [0:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // separation[23:0]
    output logic [ggbi_pkg::OUT_DATA_W-1:0]    m_tdata,
    // valid_res[0]
    output logic [0:0]                         m_tuser
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RNW  = 4'd1;
    localparam logic [3:0] S_RNE  = 4'd2;
    localparam logic [3:0] S_RSW  = 4'd3;
    localparam logic [3:0] S_MN   = 4'd4;
    localparam logic [3:0] S_MSW  = 4'd5;
    localparam logic [3:0] S_MSE  = 4'd6;
    localparam logic [3:0] S_MS   = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    localparam int ROWSUM_W = 33;
    localparam int ACC_W    = 49;
    localparam int PROD_W   = 52;
    localparam int ROW_W1   = ggbi_pkg::ROW_W + 1;

    logic [3:0]                       state_reg, state_next;
    logic [ggbi_pkg::ROW_W-1:0]       north_reg, north_next, south_reg, south_next;
    logic [ggbi_pkg::COL_W-1:0]       west_reg, west_next, east_reg, east_next;
    logic [15:0]                      r_reg, r_next, c_reg, c_next;
    logic                             ok_reg, ok_next;
    logic signed [ROWSUM_W-1:0]       row_reg, row_next;
    logic signed [ACC_W-1:0]          acc_reg, acc_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [ggbi_pkg::SEP_W-1:0]       sep_reg, sep_next;
    logic                             vres_reg, vres_next;

    logic [ggbi_pkg::HGT_W-1:0]       grid_mem [ggbi_pkg::GRID_SIZE];
    logic [ggbi_pkg::HGT_W-1:0]       rd_data_reg;
    logic                             rd_en;
    logic [ggbi_pkg::ROW_W-1:0]       rd_row;
    logic [ggbi_pkg::COL_W-1:0]       rd_col;
    logic [ggbi_pkg::ADDR_W-1:0]      rd_addr;
    logic                             wr_en;

    logic                             s_acc;
    logic [ggbi_pkg::IDX_W-1:0]       in_idx;
    logic [ggbi_pkg::HGT_W-1:0]       in_val;
    logic signed [ggbi_pkg::LAT_W-1:0] in_lat;
    logic signed [ggbi_pkg::LON_W-1:0] in_lon;
    logic                             coord_ok;
    logic [ggbi_pkg::LON_W-1:0]       lon_adj;
    logic [ggbi_pkg::LON_W-1:0]       lat_diff;
    logic [ggbi_pkg::ROW_W-1:0]       north_c;
    logic [ggbi_pkg::COL_W-1:0]       col_int, west_c;

    logic [16:0]                      rn, rs, cw, ce;
    logic signed [33:0]               mul_a;
    logic [16:0]                      mul_b;
    logic signed [PROD_W-1:0]         prod;

    assign s_tready = (state_reg == S_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign in_idx   = s_tdata[19:0];
    assign in_val   = s_tdata[35:20];
    assign in_lat   = s_tdata[59:36];
    assign in_lon   = s_tdata[84:60];

    assign coord_ok = (in_lat >= ggbi_pkg::LAT_MIN) && (in_lat <= ggbi_pkg::LAT_MAX)
                   && (in_lon >= ggbi_pkg::LON_MIN) && (in_lon <= ggbi_pkg::LON_MAX);
    assign lon_adj  = in_lon[ggbi_pkg::LON_W-1] ? (in_lon + ggbi_pkg::DEG360) : in_lon;
    assign lat_diff = ggbi_pkg::DEG90 - {in_lat[ggbi_pkg::LAT_W-1], in_lat};
    assign north_c  = lat_diff[23:14];
    assign col_int  = lon_adj[24:14];
    assign west_c   = (col_int >= ggbi_pkg::COL_W'(ggbi_pkg::GRID_COLS))
                    ? col_int - ggbi_pkg::COL_W'(ggbi_pkg::GRID_COLS) : col_int;

    assign rn = 17'h10000 - {1'b0, r_reg};
    assign rs = {1'b0, r_reg};
    assign cw = 17'h10000 - {1'b0, c_reg};
    assign ce = {1'b0, c_reg};

    // shared multiplier operands
    always_comb
    begin
        mul_a = 34'(signed'(rd_data_reg));
        mul_b = cw;
        case (state_reg)
            S_RNE:   mul_b = cw;
            S_RSW:   mul_b = ce;
            S_MN:
            begin
                mul_a = 34'(row_reg);
                mul_b = rn;
            end
            S_MSW:   mul_b = cw;
            S_MSE:   mul_b = ce;
            S_MS:
            begin
                mul_a = 34'(row_reg);
                mul_b = rs;
            end
            default: mul_b = cw;
        endcase
    end

    assign prod = PROD_W'(mul_a) * PROD_W'(signed'({1'b0, mul_b}));

    always_comb
    begin
        rd_en  = 1'b0;
        rd_row = north_reg;
        rd_col = west_reg;
        case (state_reg)
            S_RNW:   rd_en = 1'b1;
            S_RNE:
            begin
                rd_en  = 1'b1;
                rd_col = east_reg;
            end
            S_RSW:
            begin
                rd_en  = 1'b1;
                rd_row = south_reg;
            end
            S_MSW:
            begin
                rd_en  = 1'b1;
                rd_row = south_reg;
                rd_col = east_reg;
            end
            default: rd_en = 1'b0;
        endcase
    end

    assign rd_addr = ggbi_pkg::ADDR_W'(rd_row) * ggbi_pkg::ADDR_W'(ggbi_pkg::GRID_COLS)
                   + ggbi_pkg::ADDR_W'(rd_col);
    assign wr_en   = s_acc && (s_tuser[0] == ggbi_pkg::MODE_LOAD)
                   && (in_idx < ggbi_pkg::IDX_W'(ggbi_pkg::GRID_SIZE));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            grid_mem[in_idx] <= in_val;
        end
        if (rd_en)
        begin
            rd_data_reg <= grid_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        north_next    = north_reg;
        south_next    = south_reg;
        west_next     = west_reg;
        east_next     = east_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        ok_next       = ok_reg;
        row_next      = row_reg;
        acc_next      = acc_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        sep_next      = sep_reg;
        vres_next     = vres_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_acc && (s_tuser[0] == ggbi_pkg::MODE_QUERY))
                begin
                    ok_next    = coord_ok;
                    north_next = north_c;
                    south_next = (ROW_W1'(north_c) + 1'b1 >= ROW_W1'(ggbi_pkg::GRID_ROWS))
                               ? north_c : north_c + 1'b1;
                    west_next  = west_c;
                    east_next  = (west_c == ggbi_pkg::COL_W'(ggbi_pkg::GRID_COLS - 1))
                               ? '0 : west_c + 1'b1;
                    r_next     = {lat_diff[13:0], 2'b00};
                    c_next     = {lon_adj[13:0], 2'b00};
                    state_next = coord_ok ? S_RNW : S_DONE;
                end
            end
            S_RNW:   state_next = S_RNE;
            S_RNE:
            begin
                row_next   = prod[ROWSUM_W-1:0];
                state_next = S_RSW;
            end
            S_RSW:
            begin
                row_next   = row_reg + prod[ROWSUM_W-1:0];
                state_next = S_MN;
            end
            S_MN:
            begin
                acc_next   = prod[ACC_W-1:0];
                state_next = S_MSW;
            end
            S_MSW:
            begin
                row_next   = prod[ROWSUM_W-1:0];
                state_next = S_MSE;
            end
            S_MSE:
            begin
                row_next   = row_reg + prod[ROWSUM_W-1:0];
                state_next = S_MS;
            end
            S_MS:
            begin
                acc_next   = acc_reg + prod[ACC_W-1:0];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    sep_next      = ok_reg ? acc_reg[47:24] : '0;
                    vres_next     = ok_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        north_reg <= north_next;
        south_reg <= south_next;
        west_reg  <= west_next;
        east_reg  <= east_next;
        r_reg     <= r_next;
        c_reg     <= c_next;
        ok_reg    <= ok_next;
        row_reg   <= row_next;
        acc_reg   <= acc_next;
        sep_reg   <= sep_next;
        vres_reg  <= vres_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = sep_reg;
    assign m_tuser[0] = vres_reg;

    a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && (s_tuser[0] == ggbi_pkg::MODE_LOAD) |=> state_reg == S_IDLE)
        else $error("load item did not complete in one cycle");

    a_bad_coord_skips: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc && (s_tuser[0] == ggbi_pkg::MODE_QUERY) && !coord_ok |=> state_reg == S_DONE)
        else $error("invalid coordinate entered the read sequence");

    a_south_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) && (state_reg != S_DONE)
        |-> (south_reg == north_reg) || (south_reg == north_reg + 1'b1))
        else $error("south row not adjacent to north row");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("invalid result carries a non-zero separation");

endmodule
